// ----- sv/atds_pkg.sv -----
// Shared constants and codes for the arpeggio detune tone sequencer.
// Used by the divider, the detune generator and the top level. It depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package atds_pkg;

  // Field widths of the input and output beats.
  localparam int unsigned VOICE_W   = 14;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned DIV_OUT_W = 21;

  // Three voice fields arrive with each chord.
  localparam int unsigned NUM_VOICE_IN = 3;
  localparam int unsigned VOICES_DEF   = 3;

  // Widths of the shared divider. The widest dividend is duration * 100, which needs 23 bits.
  // The widest divisor is a detuned frequency of up to 17857 Hz, which needs 15 bits.
  localparam int unsigned DVD_W  = 23;
  localparam int unsigned DVS_W  = 15;
  localparam int unsigned FACT_W = 7;
  localparam int unsigned LCG_W  = 32;

  localparam logic [DVD_W-1:0]   CLOCK_HZ     = DVD_W'(1193180);
  localparam logic [LCG_W-1:0]   LCG_MUL      = 32'd1103515245;
  localparam logic [LCG_W-1:0]   LCG_ADD      = 32'd12345;
  localparam logic [LCG_W-1:0]   SEED_INIT    = 32'd12345;
  localparam logic [DUR_W-1:0]   MIN_CHORD_MS = DUR_W'(12);
  localparam logic [LEVEL_W-1:0] ARP_BASE     = LEVEL_W'(14);
  localparam logic [LEVEL_W-1:0] ARP_FLOOR    = LEVEL_W'(3);
  localparam logic [LEVEL_W-1:0] MAX_LEVEL    = LEVEL_W'(10);
  localparam logic [LEVEL_W-1:0] DETUNE_FROM  = LEVEL_W'(3);
  localparam logic [FACT_W-1:0]  PERCENT      = FACT_W'(100);
  localparam logic [FACT_W-1:0]  LEVEL_STEP   = FACT_W'(7);

  // Opcodes of the input beat.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage

`default_nettype wire

// ----- sv/atds_div.sv -----
// Restoring divider of the tone sequencer. It produces one quotient bit per cycle.
// It depends on atds_pkg for its operand widths.
`timescale 1ns / 1ps
`default_nettype none

module atds_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [atds_pkg::DVD_W-1:0]  dividend_i,
  input  logic [atds_pkg::DVS_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [atds_pkg::DVD_W-1:0]  quotient_o,
  output logic [atds_pkg::DVS_W-1:0]  remainder_o
);
  import atds_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_shift;
  logic             fits;

  always_comb begin
    rem_shift = {rem_q, quo_q[DVD_W-1]};
    fits      = rem_shift >= {1'b0, dvs_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], fits};
      rem_d = fits ? DVS_W'(rem_shift - {1'b0, dvs_q}) : rem_shift[DVS_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ----- sv/atds_lcg.sv -----
// Linear congruential generator that supplies the detune draws.
// It depends on atds_pkg for the multiplier, the increment and the seed.
`timescale 1ns / 1ps
`default_nettype none

module atds_lcg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  output logic [atds_pkg::LCG_W-1:0] seed_o
);
  import atds_pkg::*;

  logic [LCG_W-1:0] seed_q, seed_d;

  // The wrap modulo 2^32 comes from keeping only the low word of the product.
  always_comb begin
    seed_d = seed_q;
    if (advance_i) begin
      seed_d = LCG_W'(seed_q * LCG_MUL) + LCG_ADD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_INIT;
    end else begin
      seed_q <= seed_d;
    end
  end

  assign seed_o = seed_q;

endmodule

`default_nettype wire

// ----- sv/arpeggio_detune_tone_sequencer.sv -----
// Top level of the arpeggio detune tone sequencer: the sequencer, the chord state and the output register.
// It depends on atds_pkg, atds_div and atds_lcg.
`timescale 1ns / 1ps
`default_nettype none

// The block plays a chord as an arpeggio on a PC-style speaker. A beat with opcode load
// brings up to three voice frequencies, a duration and a distortion level. A beat with
// opcode tick marks one millisecond. Every input beat gives exactly one output beat. That
// beat carries the current speaker divisor (zero is silence) and three flags: a new tone
// was issued, the chord time has run out, and no chord is playing. Items are handled one
// at a time, and in_stall_o stays high until the sequencer is back in its idle state.
// A single restoring divider does all of the divisions, one quotient bit per cycle over
// 23 steps, and this divider sets the pace. A tick that does not start a segment uses no
// division. A tick that starts an undetuned segment uses one division, for the speaker
// divisor, and a detuned one (level above three) uses three. A load adds one division for
// the scaling of the chord time; a load without voices needs only that one. The output
// sits in its own register, so a new item can be accepted while the previous result
// still waits to be taken.
module arpeggio_detune_tone_sequencer #(
  parameter int unsigned VOICES = atds_pkg::VOICES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic [atds_pkg::VOICE_W-1:0]    voice_a_i,
  input  logic [atds_pkg::VOICE_W-1:0]    voice_b_i,
  input  logic [atds_pkg::VOICE_W-1:0]    voice_c_i,
  input  logic [atds_pkg::DUR_W-1:0]      duration_ms_i,
  input  logic [atds_pkg::LEVEL_W-1:0]    level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [atds_pkg::DIV_OUT_W-1:0]  speaker_divisor_o,
  output logic                            tone_update_o,
  output logic                            chord_done_o,
  output logic                            idle_o
);
  import atds_pkg::*;

  localparam int unsigned VC_W   = $clog2(VOICES + 1);
  localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  // One-hot sequencer states. A state whose name ends in GO starts the shared divider,
  // and the matching WAIT state holds until the divider signals that it is done.
  typedef enum logic [11:0] {
    S_IDLE     = 12'h001,
    S_LEN_GO   = 12'h002,
    S_LEN_WAIT = 12'h004,
    S_SEG      = 12'h008,
    S_LCG      = 12'h010,
    S_MOD_GO   = 12'h020,
    S_MOD_WAIT = 12'h040,
    S_DET_GO   = 12'h080,
    S_DET_WAIT = 12'h100,
    S_CLK_GO   = 12'h200,
    S_CLK_WAIT = 12'h400,
    S_OUT      = 12'h800
  } state_e;

  state_e                state_q, state_d;
  logic                  playing_q, playing_d;
  logic [VOICE_W-1:0]    store_q [VOICES];
  logic [VOICE_W-1:0]    store_d [VOICES];
  logic [VC_W-1:0]       vc_q, vc_d;
  logic [DUR_W-1:0]      cl_q, cl_d;
  logic [DUR_W-1:0]      tp_q, tp_d;
  logic [LEVEL_W-1:0]    seg_q, seg_d;
  logic [LEVEL_W-1:0]    arp_q, arp_d;
  logic [VIDX_W-1:0]     vp_q, vp_d;
  logic [LEVEL_W-1:0]    level_q, level_d;
  logic [DIV_OUT_W-1:0]  held_div_q, held_div_d;
  logic                  tone_flag_q, tone_flag_d;
  logic                  done_flag_q, done_flag_d;
  logic [DVD_W-1:0]      prod_q, prod_d;
  logic [DVS_W-1:0]      hz_q, hz_d;

  logic                  out_valid_q, out_valid_d;
  logic [DIV_OUT_W-1:0]  out_div_q;
  logic                  out_tone_q, out_done_q, out_idle_q;
  logic                  out_load;

  // Voice packing of a load beat.
  logic [VOICE_W-1:0]    vin [NUM_VOICE_IN];
  logic [VOICE_W-1:0]    pack_store [VOICES];
  logic [VC_W-1:0]       pack_cnt;

  // Derived values of the load and tick paths.
  logic [LEVEL_W-1:0]    lvl_clamp;
  logic [FACT_W-1:0]     len_factor;
  logic [LEVEL_W-1:0]    arp_raw, arp_calc;
  logic [DUR_W-1:0]      tp_inc, remaining;
  logic [LEVEL_W-1:0]    seg_dec;
  logic [VC_W-1:0]       vp_inc;
  logic [VIDX_W-1:0]     vp_wrap;
  logic [FACT_W-1:0]     detune_fac;
  logic                  detune;

  // Shared divider and detune generator.
  logic                  div_start, div_done;
  logic [DVD_W-1:0]      div_dvd, div_quo;
  logic [DVS_W-1:0]      div_dvs, div_rem;
  logic                  lcg_advance;
  logic [LCG_W-1:0]      lcg_seed;

  assign vin[0] = voice_a_i;
  assign vin[1] = voice_b_i;
  assign vin[2] = voice_c_i;

  // Present voices are packed in order. Voices beyond the store's depth are dropped.
  always_comb begin
    for (int j = 0; j < VOICES; j++) begin
      pack_store[j] = '0;
    end
    pack_cnt = '0;
    for (int i = 0; i < NUM_VOICE_IN; i++) begin
      if (vin[i] != '0 && pack_cnt < VC_W'(VOICES)) begin
        pack_store[pack_cnt[VIDX_W-1:0]] = vin[i];
        pack_cnt = pack_cnt + VC_W'(1);
      end
    end
  end

  always_comb begin
    lvl_clamp  = (level_i > MAX_LEVEL) ? MAX_LEVEL : level_i;
    len_factor = PERCENT - FACT_W'(LEVEL_STEP * FACT_W'(lvl_clamp));
    arp_raw    = ARP_BASE - lvl_clamp;
    arp_calc   = (arp_raw < ARP_FLOOR) ? ARP_FLOOR : arp_raw;
    tp_inc     = tp_q + DUR_W'(1);
    seg_dec    = (seg_q != '0) ? seg_q - LEVEL_W'(1) : '0;
    vp_inc     = VC_W'(vp_q) + VC_W'(1);
    vp_wrap    = (vp_inc == vc_q) ? '0 : vp_inc[VIDX_W-1:0];
    remaining  = cl_q - tp_q;
    // The detune factor is 100 - level + r, with r below twice the level.
    detune_fac = PERCENT - FACT_W'(level_q) + FACT_W'(div_rem);
    detune     = level_q > DETUNE_FROM;
  end

  // The operands for the divider are chosen by the state that starts it.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = prod_q;
    div_dvs   = DVS_W'(PERCENT);
    unique case (state_q)
      S_LEN_GO, S_DET_GO: begin
        div_start = 1'b1;
      end
      S_MOD_GO: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(lcg_seed[LCG_W-1:16]);
        div_dvs   = DVS_W'({level_q, 1'b0});
      end
      S_CLK_GO: begin
        div_start = 1'b1;
        div_dvd   = CLOCK_HZ;
        div_dvs   = hz_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign lcg_advance = (state_q == S_LCG);

  always_comb begin
    state_d     = state_q;
    playing_d   = playing_q;
    store_d     = store_q;
    vc_d        = vc_q;
    cl_d        = cl_q;
    tp_d        = tp_q;
    seg_d       = seg_q;
    arp_d       = arp_q;
    vp_d        = vp_q;
    level_d     = level_q;
    held_div_d  = held_div_q;
    tone_flag_d = tone_flag_q;
    done_flag_d = done_flag_q;
    prod_d      = prod_q;
    hz_d        = hz_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tone_flag_d = 1'b0;
          done_flag_d = 1'b0;
          if (opcode_i == OP_LOAD) begin
            // A load abandons any chord in progress. The seed is kept.
            store_d     = pack_store;
            vc_d        = pack_cnt;
            level_d     = lvl_clamp;
            arp_d       = arp_calc;
            prod_d      = DVD_W'(duration_ms_i) * DVD_W'(len_factor);
            tp_d        = '0;
            vp_d        = '0;
            playing_d   = 1'b1;
            tone_flag_d = 1'b1;
            state_d     = S_LEN_GO;
          end else if (playing_q) begin
            tp_d  = tp_inc;
            seg_d = seg_dec;
            if (tp_inc >= cl_q) begin
              // The chord ends, and the last tone stays on the speaker.
              playing_d   = 1'b0;
              seg_d       = '0;
              done_flag_d = 1'b1;
              state_d     = S_OUT;
            end else if (vc_q != '0 && seg_dec == '0) begin
              vp_d        = vp_wrap;
              tone_flag_d = 1'b1;
              state_d     = S_SEG;
            end else begin
              state_d = S_OUT;
            end
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_LEN_GO: begin
        state_d = S_LEN_WAIT;
      end
      S_LEN_WAIT: begin
        if (div_done) begin
          cl_d = (div_quo < DVD_W'(MIN_CHORD_MS)) ? MIN_CHORD_MS : div_quo[DUR_W-1:0];
          if (vc_q == '0) begin
            // A chord without voices is silent and only counts ticks.
            seg_d      = '0;
            held_div_d = '0;
            state_d    = S_OUT;
          end else begin
            state_d = S_SEG;
          end
        end
      end
      S_SEG: begin
        seg_d   = (remaining < DUR_W'(arp_q)) ? remaining[LEVEL_W-1:0] : arp_q;
        hz_d    = DVS_W'(store_q[vp_q]);
        state_d = detune ? S_LCG : S_CLK_GO;
      end
      S_LCG: begin
        state_d = S_MOD_GO;
      end
      S_MOD_GO: begin
        state_d = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (div_done) begin
          prod_d  = DVD_W'(hz_q) * DVD_W'(detune_fac);
          state_d = S_DET_GO;
        end
      end
      S_DET_GO: begin
        state_d = S_DET_WAIT;
      end
      S_DET_WAIT: begin
        if (div_done) begin
          if (div_quo == '0) begin
            // A very low voice can detune down to nothing, and then the speaker falls silent.
            held_div_d = '0;
            state_d    = S_OUT;
          end else begin
            hz_d    = div_quo[DVS_W-1:0];
            state_d = S_CLK_GO;
          end
        end
      end
      S_CLK_GO: begin
        state_d = S_CLK_WAIT;
      end
      S_CLK_WAIT: begin
        if (div_done) begin
          held_div_d = div_quo[DIV_OUT_W-1:0];
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register takes the result while the previous beat is gone or being taken.
  always_comb begin
    out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      playing_q   <= 1'b0;
      for (int j = 0; j < VOICES; j++) begin
        store_q[j] <= '0;
      end
      vc_q        <= '0;
      cl_q        <= '0;
      tp_q        <= '0;
      seg_q       <= '0;
      arp_q       <= ARP_BASE;
      vp_q        <= '0;
      level_q     <= '0;
      held_div_q  <= '0;
      tone_flag_q <= 1'b0;
      done_flag_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      playing_q   <= playing_d;
      store_q     <= store_d;
      vc_q        <= vc_d;
      cl_q        <= cl_d;
      tp_q        <= tp_d;
      seg_q       <= seg_d;
      arp_q       <= arp_d;
      vp_q        <= vp_d;
      level_q     <= level_d;
      held_div_q  <= held_div_d;
      tone_flag_q <= tone_flag_d;
      done_flag_q <= done_flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    hz_q   <= hz_d;
    if (out_load) begin
      out_div_q  <= held_div_q;
      out_tone_q <= tone_flag_q;
      out_done_q <= done_flag_q;
      out_idle_q <= !playing_q;
    end
  end

  atds_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  atds_lcg u_lcg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (lcg_advance),
    .seed_o    (lcg_seed)
  );

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign speaker_divisor_o = out_div_q;
  assign tone_update_o     = out_tone_q;
  assign chord_done_o      = out_done_q;
  assign idle_o            = out_idle_q;

  // The seed moves only on a detuned segment.
  a_seed_only_on_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LCG) |=> $stable(lcg_seed))
    else $error("detune seed changed outside a draw");

  // A result from the divider is always expected by a waiting state.
  a_div_done_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_LEN_WAIT || state_q == S_MOD_WAIT ||
                  state_q == S_DET_WAIT || state_q == S_CLK_WAIT))
    else $error("divider finished with no state waiting for it");

  // Between beats, a playing chord still has time left.
  a_time_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && playing_q) |-> (tp_q < cl_q))
    else $error("chord still playing past its length");

  // The voice pointer always names a stored voice.
  a_pointer_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && vc_q != '0) |-> (VC_W'(vp_q) < vc_q))
    else $error("voice pointer beyond the stored voices");

endmodule

`default_nettype wire
